>>> hw/rtl/box_blur_3x3_edge_average_assert.svh
// Assertion macros used by the checker file of the box blur block.
`ifndef BOX_BLUR_3X3_EDGE_AVERAGE_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_AVERAGE_ASSERT_SVH

// Checked at every rising edge outside reset.
`define BB3_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge, also while reset is asserted.
`define BB3_ASSERT_RST(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bb3_pkg.sv
// Shared constants, types and functions of the 3x3 box blur block.
`default_nettype none

package bb3_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int PIX_W       = 8;
	localparam int DIM_W       = 11;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int OROW_W      = $clog2(MAX_HEIGHT);
	// input row runs one past the image height while draining
	localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
	localparam int SUM_W       = $clog2(9 * 255 + 1);
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int CNT_W       = 3;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	// One item on its way from the accept stage to the line stores.
	typedef struct packed {
		logic             valid;
		logic [COL_W-1:0] addr;
		logic [PIX_W-1:0] sample;
		logic             emit;
		logic             left;
		logic             right;
		logic             up;
		logic             down;
		logic             last;
	} item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} result_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} pipe_busy_t;

	// ceil(2^16 / n) for n = rows * cols. With sum < 2^12 and the rounding
	// error below n, (sum * recip) >> 16 equals sum / n exactly.
	function automatic logic [RECIP_W-1:0] recip_of(input logic [1:0] nr,
			input logic [1:0] nc);
		logic [RECIP_W-1:0] r;
		r = '0;
		case ({nr, nc})
			4'b0101: r = RECIP_W'(65536);
			4'b0110, 4'b1001: r = RECIP_W'(32768);
			4'b0111, 4'b1101: r = RECIP_W'(21846);
			4'b1010: r = RECIP_W'(16384);
			4'b1011, 4'b1110: r = RECIP_W'(10923);
			4'b1111: r = RECIP_W'(7282);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bb3_line_store.sv
// Two line stores with registered read and write-to-read forwarding.
`default_nettype none

module bb3_line_store import bb3_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [COL_W-1:0] rd_addr,
	input  wire logic             wr_en,
	input  wire logic [COL_W-1:0] wr_addr,
	input  wire logic [PIX_W-1:0] wr_upper,
	input  wire logic [PIX_W-1:0] wr_middle,
	output logic      [PIX_W-1:0] rd_upper,
	output logic      [PIX_W-1:0] rd_middle
);

	logic [PIX_W-1:0] mem_upper [MAX_WIDTH];
	logic [PIX_W-1:0] mem_middle [MAX_WIDTH];
	logic [PIX_W-1:0] ram_upper_q, ram_middle_q;
	logic [PIX_W-1:0] fwd_upper_q, fwd_middle_q;
	logic             fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_upper[wr_addr]  <= wr_upper;
			mem_middle[wr_addr] <= wr_middle;
		end
		if (rd_en) begin
			ram_upper_q  <= mem_upper[rd_addr];
			ram_middle_q <= mem_middle[rd_addr];
		end
		fwd_upper_q  <= wr_upper;
		fwd_middle_q <= wr_middle;
	end

	// same-entry write in the read cycle: RAM gives old data, take the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_upper  = fwd_q ? fwd_upper_q : ram_upper_q;
	assign rd_middle = fwd_q ? fwd_middle_q : ram_middle_q;

endmodule

`default_nettype wire

>>> hw/rtl/bb3_ctrl.sv
// Configuration registers, raster counters and the accept stage.
`default_nettype none

module bb3_ctrl import bb3_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             func,
	input  wire logic [PIX_W-1:0] pixel_in,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic             cfg_index,
	input  wire logic [DIM_W-1:0] cfg_data,
	input  wire logic             room,
	output logic                  rd_en,
	output logic      [COL_W-1:0] rd_addr,
	output item_t                 item_s1
);

	logic [DIM_W-1:0]  width_q, height_q;
	logic [COL_W-1:0]  in_col_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [OROW_W-1:0] out_row_q;

	logic             take, frame_done, enter, emit, last, cfg_take;
	logic             left, right, up, down;
	logic [COL_W:0]   in_col_inc, out_col_inc;
	logic [OROW_W:0]  out_row_inc;
	logic             in_wrap, out_wrap;
	logic [PIX_W-1:0] sample;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) r = DIM_W'(1);
		else if (v > maxv) r = maxv;
		return r;
	endfunction

	assign in_ready  = room;
	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid;

	assign take       = in_valid && room;
	assign frame_done = in_row_q >= ROW_W'(height_q);
	// a drain tick before the frame is complete is dropped
	assign enter      = take && (frame_done || !func);
	assign sample     = frame_done ? '0 : pixel_in;
	assign emit       = (in_row_q >= ROW_W'(2)) ||
	                    ((in_row_q == ROW_W'(1)) && (in_col_q != '0));

	assign in_col_inc  = {1'b0, in_col_q} + 1'b1;
	assign in_wrap     = in_col_inc >= (COL_W+1)'(width_q);
	assign out_col_inc = {1'b0, out_col_q} + 1'b1;
	assign out_row_inc = {1'b0, out_row_q} + 1'b1;
	assign out_wrap    = out_col_inc >= (COL_W+1)'(width_q);

	assign left  = out_col_q != '0;
	assign right = !out_wrap;
	assign up    = out_row_q != '0;
	assign down  = out_row_inc < (OROW_W+1)'(height_q);
	assign last  = !down && out_wrap;

	assign rd_en   = enter;
	assign rd_addr = in_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= DIM_W'(MAX_WIDTH);
			height_q  <= DIM_W'(MAX_HEIGHT);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			item_s1   <= '0;
		end else begin
			item_s1.valid <= enter;
			if (cfg_take) begin
				case (cfg_reg_t'(cfg_index))
					REG_WIDTH: width_q <= clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
					REG_HEIGHT: height_q <= clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
					default: width_q <= width_q;
				endcase
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else if (enter) begin
				item_s1.addr   <= in_col_q;
				item_s1.sample <= sample;
				item_s1.emit   <= emit;
				item_s1.left   <= left;
				item_s1.right  <= right;
				item_s1.up     <= up;
				item_s1.down   <= down;
				item_s1.last   <= last;
				if (emit && last) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else begin
					if (in_wrap) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + 1'b1;
					end else begin
						in_col_q <= in_col_inc[COL_W-1:0];
					end
					if (emit) begin
						if (out_wrap) begin
							out_col_q <= '0;
							out_row_q <= out_row_inc[OROW_W-1:0];
						end else begin
							out_col_q <= out_col_inc[COL_W-1:0];
						end
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/bb3_datapath.sv
// Line store write-back, 3x3 window, masked sum and reciprocal divide.
`default_nettype none

module bb3_datapath import bb3_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire item_t            item_s1,
	input  wire logic [PIX_W-1:0] rd_upper,
	input  wire logic [PIX_W-1:0] rd_middle,
	output logic                  wr_en,
	output logic      [COL_W-1:0] wr_addr,
	output logic      [PIX_W-1:0] wr_upper,
	output logic      [PIX_W-1:0] wr_middle,
	output logic                  push,
	output result_t               push_data,
	output pipe_busy_t            busy
);

	logic [PIX_W-1:0] win_q [3][3];
	logic [PIX_W-1:0] col [3];

	logic               valid_s2, left_s2, right_s2, up_s2, down_s2, last_s2;
	logic               valid_s3, last_s3;
	logic [SUM_W-1:0]   sum_s3;
	logic [RECIP_W-1:0] recip_s3;

	logic [SUM_W-1:0]   row_sum [3];
	logic [SUM_W-1:0]   sum;
	logic [1:0]         nr, nc;
	logic [PROD_W-1:0]  prod;

	assign col[0] = rd_upper;
	assign col[1] = rd_middle;
	assign col[2] = item_s1.sample;

	// rows shift up by one line in the stores
	assign wr_en     = item_s1.valid;
	assign wr_addr   = item_s1.addr;
	assign wr_upper  = rd_middle;
	assign wr_middle = item_s1.sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (item_s1.valid) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
				win_q[r][2] <= col[r];
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			row_sum[r] = SUM_W'(win_q[r][1]) +
			             (left_s2 ? SUM_W'(win_q[r][0]) : '0) +
			             (right_s2 ? SUM_W'(win_q[r][2]) : '0);
		end
		sum = row_sum[1] + (up_s2 ? row_sum[0] : '0) + (down_s2 ? row_sum[2] : '0);
		nr  = 2'd1 + {1'b0, up_s2} + {1'b0, down_s2};
		nc  = 2'd1 + {1'b0, left_s2} + {1'b0, right_s2};
	end

	assign prod = PROD_W'(sum_s3) * PROD_W'(recip_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= item_s1.valid && item_s1.emit;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		left_s2  <= item_s1.left;
		right_s2 <= item_s1.right;
		up_s2    <= item_s1.up;
		down_s2  <= item_s1.down;
		last_s2  <= item_s1.last;
		sum_s3   <= sum;
		recip_s3 <= recip_of(nr, nc);
		last_s3  <= last_s2;
	end

	assign push            = valid_s3;
	assign push_data.pixel = prod[RECIP_SHIFT +: PIX_W];
	assign push_data.last  = last_s3;
	assign busy.s2         = valid_s2;
	assign busy.s3         = valid_s3;

endmodule

`default_nettype wire

>>> hw/rtl/bb3_out_fifo.sv
// Small output queue that decouples the pipeline from the result consumer.
`default_nettype none

module bb3_out_fifo import bb3_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire result_t          push_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [PIX_W-1:0] pixel_out,
	output logic                  last_pixel,
	output logic      [CNT_W-1:0] count
);

	result_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	assign out_valid  = count_q != '0;
	assign pop        = out_valid && out_ready;
	assign pixel_out  = mem_q[rd_ptr_q].pixel;
	assign last_pixel = mem_q[rd_ptr_q].last;
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// never pushed when full: the accept side holds a credit per entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/box_blur_3x3_edge_average.sv
// A result passes the accept stage, stages s2 and s3 and the output queue before it shows.
// New items enter while earlier ones are still in the three pipeline stages, but only while
// queue entries plus items in those stages number under four, so input can stall anyway.
// Consumer stalls are absorbed by the four-entry output queue.
// Reset: counters and window clear, width and height return to 1024, queue empties.
// The line stores hold no reset value and get no clearing pass; edge masks hide stale rows.
`default_nettype none

module box_blur_3x3_edge_average import bb3_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             func,
	input  wire logic [PIX_W-1:0] pixel_in,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [PIX_W-1:0] pixel_out,
	output logic                  last_pixel,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic             cfg_index,
	input  wire logic [DIM_W-1:0] cfg_data
);

	item_t            item_s1;
	pipe_busy_t       busy;
	result_t          push_data;
	logic             push, room, rd_en, wr_en;
	logic [COL_W-1:0] rd_addr, wr_addr;
	logic [PIX_W-1:0] rd_upper, rd_middle, wr_upper, wr_middle;
	logic [CNT_W-1:0] fifo_count, occupancy;

	// queue entries plus requests still in the pipeline
	assign occupancy = fifo_count + CNT_W'(item_s1.valid) + CNT_W'(busy.s2) +
	                   CNT_W'(busy.s3);
	assign room      = occupancy < CNT_W'(FIFO_DEPTH);

	bb3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.pixel_in  (pixel_in),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.room      (room),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.item_s1   (item_s1)
	);

	bb3_line_store u_line_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_upper  (wr_upper),
		.wr_middle (wr_middle),
		.rd_upper  (rd_upper),
		.rd_middle (rd_middle)
	);

	bb3_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_s1   (item_s1),
		.rd_upper  (rd_upper),
		.rd_middle (rd_middle),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_upper  (wr_upper),
		.wr_middle (wr_middle),
		.push      (push),
		.push_data (push_data),
		.busy      (busy)
	);

	bb3_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.last_pixel (last_pixel),
		.count      (fifo_count)
	);

endmodule

`default_nettype wire

>>> hw/rtl/bb3_checker.sv
// Port-level checker for the box blur block and its bind to the top level.
`default_nettype none

`include "box_blur_3x3_edge_average_assert.svh"

module bb3_checker import bb3_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [PIX_W-1:0] pixel_out,
	input wire logic             last_pixel,
	input wire logic             cfg_ready
);

	`BB3_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(last_pixel), "stalled result changed or vanished")
	`BB3_ASSERT_RST(a_reset_empty, !arst_n |-> !out_valid, "result shown during reset")
	`BB3_ASSERT(a_backpressure, !in_ready |-> out_valid, "input stalled with no result waiting")
	`BB3_ASSERT(a_result_latency, $rose(out_valid) |-> $past(in_valid && in_ready, 4), "result without a request four cycles earlier")
	`BB3_ASSERT(a_cfg_ready, cfg_ready, "config channel not ready")

endmodule

bind box_blur_3x3_edge_average bb3_checker u_bb3_checker (.*);

`default_nettype wire
